### src/cdsch_pkg.sv
// Shared widths, register indexes and word types of the C-SCAN disk scheduler.
`timescale 1ns / 1ps

package cdsch_pkg;

  localparam int TRACK_W   = 16;
  localparam int TOTAL_W   = 18;
  localparam int SUM_W     = TRACK_W + 1;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_TRACK     = 1'd1;

  localparam logic [TRACK_W-1:0] START_POSITION_RST = 16'd0;
  localparam logic [TRACK_W-1:0] LAST_TRACK_RST     = 16'd199;

  typedef struct packed {
    logic [TRACK_W-1:0] request_track;
    logic               batch_end;
  } in_word_t;

  typedef struct packed {
    logic [TRACK_W-1:0] served_track;
    logic [TOTAL_W-1:0] head_travel;
    logic               is_last;
    logic               dropped_any;
  } out_word_t;

endpackage

### src/cscan_disk_scheduler_core.sv
// C-SCAN disk scheduler: batch request store, selection scan and result register.
`timescale 1ns / 1ps

//  Channel   Direction  Signals                        Word
//  req       in         req_valid / req_ready / req    one track request
//  res       out        res_valid / res_ready / res    one served track
//  cfg       in         cfg_we / cfg_index / cfg_data  register write, no wait
//
// A request word is taken while the block collects a batch.
// For each served track of a batch of N stored requests, one pass over the
// request memory through its single read port (N reads, the last read data,
// then closing the scan) finds the next track in order, and the emit state
// moves the word to the result register. The last word of a batch first goes
// through the states ST_SUM1 and ST_SUM2, which add up the total movement.
// Reset clears the stored count, the drop flag and the result valid flag; the
// request memory itself is not cleared.
// A stalled result holds the scheduler in its emit state; the request side
// stays closed until the last word of the batch is loaded.

module cscan_disk_scheduler_core #(
  parameter int MAX_BATCH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cdsch_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cdsch_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  cdsch_pkg::in_word_t            req,
  output logic                           res_valid,
  input  logic                           res_ready,
  output cdsch_pkg::out_word_t           res
);

  localparam int CW = $clog2(MAX_BATCH + 1);
  localparam int AW = $clog2(MAX_BATCH);
  localparam int TW = cdsch_pkg::TRACK_W;
  localparam int KW = TW + AW;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_SUM1 = 5'b00100,
    ST_SUM2 = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [TW-1:0] start_position;
  logic [TW-1:0] last_track;

  // Request memory and its registered read port.
  logic [TW-1:0] mem [MAX_BATCH];
  logic [TW-1:0] rd_data;
  logic [AW-1:0] rd_idx;
  logic          rd_vld;
  logic [CW-1:0] rd_ptr;
  logic          rd_en;

  // Batch bookkeeping.
  logic [CW-1:0] count;
  logic [CW-1:0] count_after;
  logic [CW-1:0] emitted;
  logic          drop_seen;

  // Selection state: words leave in order of rotated key, ties by index.
  logic [KW-1:0] prev_key;
  logic [KW-1:0] best_key;
  logic [KW-1:0] cand_key;
  logic [TW-1:0] best_val;
  logic          best_vld;
  logic          first;

  // Movement bookkeeping.
  logic [TW-1:0] pos_hi;
  logic [TW-1:0] lo_max;
  logic [TW-1:0] hi_fin;
  logic [TW-1:0] lo_fin;
  logic [TW-1:0] span;
  logic [cdsch_pkg::SUM_W-1:0]   sum_a;
  logic [cdsch_pkg::SUM_W-1:0]   sum_b;
  logic [cdsch_pkg::TOTAL_W-1:0] total;

  logic accept;
  logic store;
  logic take;
  logic scan_done;
  logic emit_last;
  logic out_free;
  logic load;
  logic batch_go;

  // Requests are taken only while the batch is being collected.
  assign req_ready   = (state == ST_IDLE);
  assign accept      = req_valid && req_ready;
  assign store       = accept && (req.request_track <= last_track)
                       && (count < CW'(MAX_BATCH));
  assign count_after = store ? count + CW'(1) : count;
  // An end word that leaves the batch empty just resets it, with no result.
  assign batch_go    = accept && req.batch_end && (count_after != '0);

  // The scan streams one address per cycle; data arrives in the following cycle.
  assign rd_en     = (state == ST_SCAN) && (rd_ptr < count);
  assign scan_done = (state == ST_SCAN) && !rd_en && !rd_vld;

  // Rotating by the start position puts tracks at or above it first and
  // the lower tracks after them, each group in ascending order.
  assign cand_key = {rd_data - start_position, rd_idx};
  assign take     = rd_vld && (first || (cand_key > prev_key))
                    && (!best_vld || (cand_key < best_key));

  assign emit_last = ((emitted + CW'(1)) == count);
  assign out_free  = !res_valid || res_ready;
  assign load      = (state == ST_EMIT) && out_free;

  // Head travel: up to the highest upper track, across to the last track,
  // back to track 0, then up to the highest lower track.
  assign hi_fin = (best_val >= start_position) ? best_val : pos_hi;
  assign lo_fin = (best_val <  start_position) ? best_val : lo_max;
  assign span   = (hi_fin >= last_track) ? hi_fin - last_track : last_track - hi_fin;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (batch_go) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_next = emit_last ? ST_SUM1 : ST_EMIT;
      end
      ST_SUM1: state_next = ST_SUM2;
      ST_SUM2: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = emit_last ? ST_IDLE : ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position <= cdsch_pkg::START_POSITION_RST;
      last_track     <= cdsch_pkg::LAST_TRACK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cdsch_pkg::CFG_START_POSITION: start_position <= cfg_data[TW-1:0];
        cdsch_pkg::CFG_LAST_TRACK:     last_track     <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (store) mem[count[AW-1:0]] <= req.request_track;
    if (rd_en) rd_data <= mem[rd_ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      drop_seen <= 1'b0;
      rd_ptr    <= '0;
      rd_vld    <= 1'b0;
      best_vld  <= 1'b0;
      first     <= 1'b0;
      emitted   <= '0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (accept) begin
        if (req.batch_end && (count_after == '0)) begin
          count     <= '0;
          drop_seen <= 1'b0;
        end else begin
          count <= count_after;
          if (!store) drop_seen <= 1'b1;
        end
      end
      if (batch_go) begin
        rd_ptr   <= '0;
        best_vld <= 1'b0;
        first    <= 1'b1;
        emitted  <= '0;
      end
      if (rd_en) rd_ptr <= rd_ptr + CW'(1);
      if (take) best_vld <= 1'b1;
      if (load) begin
        if (emit_last) begin
          count     <= '0;
          drop_seen <= 1'b0;
        end else begin
          rd_ptr   <= '0;
          best_vld <= 1'b0;
          first    <= 1'b0;
          emitted  <= emitted + CW'(1);
        end
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_ptr[AW-1:0];
    if (take) begin
      best_key <= cand_key;
      best_val <= rd_data;
    end
    if (batch_go) begin
      pos_hi <= start_position;
      lo_max <= '0;
    end
    if (load && !emit_last) begin
      prev_key <= best_key;
      if (best_val >= start_position) begin
        pos_hi <= best_val;
      end else begin
        lo_max <= best_val;
      end
    end
    if (state == ST_SUM1) begin
      sum_a <= {1'b0, hi_fin - start_position} + {1'b0, last_track};
      sum_b <= {1'b0, span} + {1'b0, lo_fin};
    end
    if (state == ST_SUM2) begin
      total <= {1'b0, sum_a} + {1'b0, sum_b};
    end
    if (load) begin
      res.served_track <= best_val;
      res.head_travel  <= emit_last ? total : '0;
      res.is_last      <= emit_last;
      res.dropped_any  <= drop_seen;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BATCH))
    else $error("stored count beyond batch capacity");

  a_res_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_EMIT))
    else $error("result word raised outside the emit state");

  a_batch_cleared: assert property (@(posedge clk) disable iff (rst)
    load && emit_last |=> (count == '0) && !drop_seen && (state == ST_IDLE))
    else $error("batch not cleared after its last word");

  a_total_on_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.is_last |-> (res.head_travel == '0))
    else $error("total movement on a word that is not last");

  a_scan_finds: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> best_vld)
    else $error("scan ended without a candidate");

endmodule
